FILE: sv/slot_allocator_update_coalescer_assert.svh
// Assertion macros used by the coalescer datapath (sauc_dp).
// Both expect a signal named clock in the calling scope; SAUC_ASSERT also expects reset.
`ifndef SLOT_ALLOCATOR_UPDATE_COALESCER_ASSERT_SVH
`define SLOT_ALLOCATOR_UPDATE_COALESCER_ASSERT_SVH

// Checked only outside reset.
`define SAUC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define SAUC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/sauc_pkg.sv
// ----------------------------------------------------------------------------
// sauc_pkg
// Types, codes and helpers of the slot allocator / update coalescer.
// ----------------------------------------------------------------------------
package sauc_pkg;

   localparam int MAX_SLOTS_DEF = 1024;
   localparam int MAX_INST_W    = 11;
   localparam int SLOT_W        = 16;
   localparam int GEOM_W        = 32;
   localparam int OUT_SLOT_W    = 10;
   localparam int OUT_CNT_W     = 11;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam logic [MAX_INST_W-1:0] MAX_INST_RST = 11'd1024;
   localparam logic [GEOM_W-1:0]     PRESERVE_ID  = 32'hFFFF_FFFF;

   // register index, taken from paddr[2]
   localparam logic REG_MAX_INST = 1'b0;

   typedef enum logic [1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_FREE   = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_FLUSH  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SLOT  = 2'd1,
      ST_INVALID  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CLS_NEG  = 2'd0,
      CLS_ZERO = 2'd1,
      CLS_POS  = 2'd2,
      CLS_NAN  = 2'd3
   } wclass_type;

   typedef struct packed {
      logic clear;    // shadow clearing pass
      logic capture;  // item accepted, launch first reads
      logic rd;       // launch pending list read
      logic exec;     // evaluate and commit
   } sauc_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } sauc_stat_type;

   function automatic wclass_type classify_w(input logic [31:0] w);
      wclass_type c;
      if (w[30:23] == 8'hFF && w[22:0] != 23'd0) begin
         c = CLS_NAN;
      end else if (w[30:0] == 31'd0) begin
         c = CLS_ZERO;
      end else if (w[31]) begin
         c = CLS_NEG;
      end else begin
         c = CLS_POS;
      end
      return c;
   endfunction

endpackage

FILE: sv/sauc_if.sv
// ----------------------------------------------------------------------------
// sauc_req_if / sauc_rsp_if
// Valid/ready channels of the coalescer.
// ----------------------------------------------------------------------------
interface sauc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] slot;
   logic [31:0] geometry_id;
   logic [31:0] bounds_w_bits;

   modport source (output valid, action, slot, geometry_id, bounds_w_bits, input ready);
   modport sink   (input valid, action, slot, geometry_id, bounds_w_bits, output ready);
endinterface

interface sauc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [9:0]  slot_out;
   logic [9:0]  pending_index;
   logic        write_payload;
   logic        write_geometry;
   logic [31:0] geometry_value;
   logic        write_bounds;
   logic        new_entry;
   logic [10:0] pending_count;
   logic [10:0] high_water;

   modport source (output valid, status, slot_out, pending_index, write_payload,
                   write_geometry, geometry_value, write_bounds, new_entry,
                   pending_count, high_water, input ready);
   modport sink   (input valid, status, slot_out, pending_index, write_payload,
                   write_geometry, geometry_value, write_bounds, new_entry,
                   pending_count, high_water, output ready);
endinterface

FILE: sv/sauc_ram.sv
// ----------------------------------------------------------------------------
// sauc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sauc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/sauc_ctrl.sv
// ----------------------------------------------------------------------------
// sauc_ctrl
// Sequencer: clearing pass, accept, map read, list read, commit.
// ----------------------------------------------------------------------------
module sauc_ctrl import sauc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  sauc_stat_type stat,
   output sauc_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (stat.clear_done) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= S_READ;
                  ready_ff <= 1'b0;
               end
            end
            S_READ: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               // commit waits for the output register to free up
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_CLEAR;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready   = ready_ff;
   assign cmd.clear   = (state_ff == S_CLEAR);
   assign cmd.capture = req_valid && ready_ff;
   assign cmd.rd      = (state_ff == S_READ);
   assign cmd.exec    = (state_ff == S_EXEC);

endmodule

FILE: sv/sauc_dp.sv
// ----------------------------------------------------------------------------
// sauc_dp
// Datapath: counters, free stack, geometry shadow, pending map and list,
// result register.
// ----------------------------------------------------------------------------
`include "slot_allocator_update_coalescer_assert.svh"

module sauc_dp import sauc_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sauc_cmd_type          cmd,
   output sauc_stat_type         stat,
   input  logic [MAX_INST_W-1:0] max_instances,
   input  logic [1:0]            req_action,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [GEOM_W-1:0]     req_geometry_id,
   input  logic [31:0]           req_bounds_w_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [OUT_SLOT_W-1:0] rsp_slot_out,
   output logic [OUT_SLOT_W-1:0] rsp_pending_index,
   output logic                  rsp_write_payload,
   output logic                  rsp_write_geometry,
   output logic [GEOM_W-1:0]     rsp_geometry_value,
   output logic                  rsp_write_bounds,
   output logic                  rsp_new_entry,
   output logic [OUT_CNT_W-1:0]  rsp_pending_count,
   output logic [OUT_CNT_W-1:0]  rsp_high_water
);

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;

   // captured item
   action_type        action_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [GEOM_W-1:0] gid_ff;
   logic [31:0]       wbits_ff;

   logic [CW-1:0] free_top_ff, free_top_in;
   logic [CW-1:0] next_free_ff, next_free_in;
   logic [CW-1:0] hwm_ff, hwm_in;
   logic [CW-1:0] total_ff, total_in;
   logic [SW-1:0] clr_cnt_ff;

   // memory ports
   logic              stk_we, shd_we, pmap_we, list_we;
   logic [SW-1:0]     stk_waddr, shd_waddr, pmap_waddr, list_waddr;
   logic [SW-1:0]     stk_wdata, list_wdata, stk_rdata, list_rdata;
   logic [GEOM_W-1:0] shd_wdata, shd_rdata;
   logic [SW+1:0]     pmap_wdata, pmap_rdata;

   // evaluation
   logic          fire;
   logic [XW-1:0] limit_x;
   logic          slot_ok;
   logic [SW-1:0] slot_idx;
   wclass_type    cls, dcls;
   logic [SW-1:0] map_idx;
   logic          hit;
   logic          skip;
   logic [GEOM_W-1:0] gsub;
   logic [SW-1:0] gslot;
   logic          granted;

   status_type    st_c;
   logic [SW-1:0] sout_c, pidx_c;
   logic          wp_c, wg_c, wb_c, ne_c;
   logic [GEOM_W-1:0] gval_c;
   logic [CW-1:0] cnt_c;

   logic          rsp_valid_ff;

   assign fire          = cmd.exec && stat.out_free;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.clear_done = (clr_cnt_ff == SW'(MAX_SLOTS - 1));

   assign limit_x  = (XW'(max_instances) < XW'(MAX_SLOTS)) ? XW'(max_instances)
                                                            : XW'(MAX_SLOTS);
   assign slot_ok  = (XW'(slot_ff) < limit_x);
   assign slot_idx = slot_ff[SW-1:0];
   assign cls      = classify_w(wbits_ff);
   assign map_idx  = pmap_rdata[SW+1:2];
   assign dcls     = wclass_type'(pmap_rdata[1:0]);
   // an entry is live only if its list position is below the count and points back
   assign hit      = (CW'(map_idx) < total_ff) && (list_rdata == slot_idx);
   assign skip     = (cls == CLS_ZERO && dcls == CLS_POS) ||
                     (dcls == CLS_ZERO && cls == CLS_NEG);
   assign gsub     = (gid_ff == PRESERVE_ID) ? shd_rdata : gid_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= action_type'(req_action);
         slot_ff   <= req_slot;
         gid_ff    <= req_geometry_id;
         wbits_ff  <= req_bounds_w_bits;
      end
   end

   always_comb begin
      free_top_in  = free_top_ff;
      next_free_in = next_free_ff;
      hwm_in       = hwm_ff;
      total_in     = total_ff;
      stk_we       = 1'b0;
      stk_waddr    = SW'(free_top_ff);
      stk_wdata    = slot_idx;
      shd_we       = 1'b0;
      shd_waddr    = slot_idx;
      shd_wdata    = PRESERVE_ID;
      pmap_we      = 1'b0;
      pmap_waddr   = slot_idx;
      pmap_wdata   = {map_idx, cls};
      list_we      = 1'b0;
      list_waddr   = SW'(total_ff);
      list_wdata   = slot_idx;
      granted      = 1'b0;
      gslot        = stk_rdata;
      st_c         = ST_OK;
      sout_c       = '0;
      pidx_c       = '0;
      wp_c         = 1'b0;
      wg_c         = 1'b0;
      wb_c         = 1'b0;
      ne_c         = 1'b0;
      gval_c       = '0;
      if (cmd.clear) begin
         shd_we    = 1'b1;
         shd_waddr = clr_cnt_ff;
      end else if (fire) begin
         unique case (action_ff)
            ACT_ALLOC: begin
               if (free_top_ff != '0) begin
                  free_top_in = free_top_ff - 1'b1;
                  granted     = 1'b1;
               end else if (XW'(next_free_ff) < limit_x) begin
                  gslot        = SW'(next_free_ff);
                  next_free_in = next_free_ff + 1'b1;
                  granted      = 1'b1;
               end else begin
                  st_c = ST_NO_SLOT;
               end
               if (granted) begin
                  sout_c = gslot;
                  if ((CW'(gslot) + 1'b1) > hwm_ff) begin
                     hwm_in = CW'(gslot) + 1'b1;
                  end
               end
            end
            ACT_FREE: begin
               if (!slot_ok) begin
                  st_c = ST_INVALID;
               end else if (free_top_ff >= CW'(MAX_SLOTS)) begin
                  st_c = ST_FULL;
               end else begin
                  stk_we      = 1'b1;
                  free_top_in = free_top_ff + 1'b1;
                  shd_we      = 1'b1;
               end
            end
            ACT_UPDATE: begin
               if (!slot_ok) begin
                  st_c = ST_INVALID;
               end else begin
                  gval_c = gsub;
                  if (gid_ff != PRESERVE_ID) begin
                     shd_we    = 1'b1;
                     shd_wdata = gid_ff;
                  end
                  if (hit) begin
                     pidx_c = map_idx;
                     if (!skip) begin
                        wp_c = 1'b1;
                        wg_c = (gsub != PRESERVE_ID);
                        if (cls == CLS_ZERO || cls == CLS_POS) begin
                           wb_c    = 1'b1;
                           pmap_we = 1'b1;
                        end
                     end
                  end else begin
                     pidx_c     = SW'(total_ff);
                     pmap_we    = 1'b1;
                     pmap_wdata = {SW'(total_ff), cls};
                     list_we    = 1'b1;
                     total_in   = total_ff + 1'b1;
                     wp_c       = 1'b1;
                     wg_c       = 1'b1;
                     wb_c       = 1'b1;
                     ne_c       = 1'b1;
                  end
               end
            end
            ACT_FLUSH: begin
               total_in = '0;
            end
            default: begin
            end
         endcase
      end
      cnt_c = (action_ff == ACT_FLUSH) ? total_ff : total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_top_ff  <= '0;
         next_free_ff <= '0;
         hwm_ff       <= '0;
         total_ff     <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_top_ff  <= free_top_in;
         next_free_ff <= next_free_in;
         hwm_ff       <= hwm_in;
         total_ff     <= total_in;
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status         <= st_c;
         rsp_slot_out       <= OUT_SLOT_W'(sout_c);
         rsp_pending_index  <= OUT_SLOT_W'(pidx_c);
         rsp_write_payload  <= wp_c;
         rsp_write_geometry <= wg_c;
         rsp_geometry_value <= gval_c;
         rsp_write_bounds   <= wb_c;
         rsp_new_entry      <= ne_c;
         rsp_pending_count  <= OUT_CNT_W'(cnt_c);
         rsp_high_water     <= OUT_CNT_W'(hwm_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   sauc_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .re(cmd.capture), .raddr(SW'(free_top_ff - 1'b1)), .rdata(stk_rdata)
   );

   sauc_ram #(.WIDTH(GEOM_W), .DEPTH(MAX_SLOTS)) u_shadow (
      .clock(clock), .we(shd_we), .waddr(shd_waddr), .wdata(shd_wdata),
      .re(cmd.capture), .raddr(req_slot[SW-1:0]), .rdata(shd_rdata)
   );

   // per slot: list position and bounds class of its pending entry
   sauc_ram #(.WIDTH(SW + 2), .DEPTH(MAX_SLOTS)) u_pmap (
      .clock(clock), .we(pmap_we), .waddr(pmap_waddr), .wdata(pmap_wdata),
      .re(cmd.capture), .raddr(req_slot[SW-1:0]), .rdata(pmap_rdata)
   );

   // per pending entry: owning slot
   sauc_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_list (
      .clock(clock), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
      .re(cmd.rd), .raddr(map_idx), .rdata(list_rdata)
   );

   `SAUC_ASSERT(a_top_bound, (free_top_ff <= CW'(MAX_SLOTS)), "free stack over depth")
   `SAUC_ASSERT(a_total_bound, (total_ff <= CW'(MAX_SLOTS)), "pending count over depth")
   `SAUC_ASSERT(a_fire_loads, (fire |=> rsp_valid_ff), "result not presented")
   `SAUC_ASSERT_ALWAYS(a_quiet_clear, (cmd.clear |-> !rsp_valid_ff), "result in clear")

endmodule

FILE: sv/slot_allocator_update_coalescer.sv
// ----------------------------------------------------------------------------
// slot_allocator_update_coalescer
// Instance slot allocator with free stack and per-frame update coalescer.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item (action, slot, geometry_id, bounds_w_bits);
//   rsp_chan returns exactly one result item per request, in order.
//   csr_* is an APB write/read port for max_instances at byte address 0.
// Sequence:
//   An accepted item commits once rsp_chan is free; req_chan.ready stays low
//   until that commit, so items do not overlap; the per-slot pending map must
//   be read before the pending list can be checked at the position it holds,
//   so each item makes two dependent synchronous memory reads before it commits.
// Reset:
//   Counters and pending count go to zero and max_instances to 1024. The
//   geometry shadow is then swept to all ones, one entry per cycle, over all
//   MAX_SLOTS entries; req_chan.ready stays low until that finishes.
// Stall:
//   The result register holds while rsp_chan.ready is low; the next item is
//   still accepted and waits in the commit step until the register frees.
// ----------------------------------------------------------------------------
module slot_allocator_update_coalescer import sauc_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sauc_req_if.sink              req_chan,
   sauc_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   sauc_cmd_type          cmd;
   sauc_stat_type         stat;
   logic [MAX_INST_W-1:0] max_inst_ff;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_inst_ff <= MAX_INST_RST;
      end else if (csr_wr && csr_paddr[2] == REG_MAX_INST) begin
         max_inst_ff <= csr_pwdata[MAX_INST_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MAX_INST) ? CSR_DATA_W'(max_inst_ff) : '0;

   sauc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sauc_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .max_instances      (max_inst_ff),
      .req_action         (req_chan.action),
      .req_slot           (req_chan.slot),
      .req_geometry_id    (req_chan.geometry_id),
      .req_bounds_w_bits  (req_chan.bounds_w_bits),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_status         (rsp_chan.status),
      .rsp_slot_out       (rsp_chan.slot_out),
      .rsp_pending_index  (rsp_chan.pending_index),
      .rsp_write_payload  (rsp_chan.write_payload),
      .rsp_write_geometry (rsp_chan.write_geometry),
      .rsp_geometry_value (rsp_chan.geometry_value),
      .rsp_write_bounds   (rsp_chan.write_bounds),
      .rsp_new_entry      (rsp_chan.new_entry),
      .rsp_pending_count  (rsp_chan.pending_count),
      .rsp_high_water     (rsp_chan.high_water)
   );

endmodule

FILE: test/slot_allocator_update_coalescer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_allocator_update_coalescer_test
// Drives allocate, free, update and flush items through the coalescer under
// random idling on both channels, at several max_instances settings. A model
// of the slot tables predicts every result item; results are checked in order.
// ----------------------------------------------------------------------------
module slot_allocator_update_coalescer_test;
   import sauc_pkg::*;

   typedef struct {
      status_type  status;
      logic [9:0]  slot_out;
      logic [9:0]  pend_index;
      logic        wr_payload;
      logic        wr_geom;
      logic [31:0] geom_value;
      logic        wr_bounds;
      logic        new_entry;
      logic [10:0] count;
      logic [10:0] high_water;
   } slot_result_type;

   class slot_table_scoreboard;
      int unsigned     limit_reg;
      int unsigned     free_stack[1024];
      int unsigned     free_top, next_slot, high_mark, pend_total;
      logic [31:0]     geom_shadow[1024];
      bit              pend_valid[1024];
      int unsigned     pend_index[1024];
      wclass_type      pend_class[1024];
      slot_result_type expected_results[$];
      int              errors;

      function new();
         limit_reg = 1024;
         free_top = 0; next_slot = 0; high_mark = 0; pend_total = 0;
         errors = 0;
         foreach (geom_shadow[i]) begin
            geom_shadow[i] = PRESERVE_ID;
            pend_valid[i] = 0;
         end
      endfunction

      function int unsigned usable();
         return (limit_reg < 1024) ? limit_reg : 1024;
      endfunction

      function wclass_type w_class(logic [31:0] w);
         if (w[30:23] == 8'hFF && w[22:0] != 0) return CLS_NAN;
         if (w[30:0] == 0) return CLS_ZERO;
         if (w[31]) return CLS_NEG;
         return CLS_POS;
      endfunction

      function void note_request(action_type act, logic [15:0] slot, logic [31:0] gid,
                                 logic [31:0] w);
         slot_result_type r;
         int unsigned s;
         wclass_type c, old;
         r = '{status: ST_OK, slot_out: 0, pend_index: 0, wr_payload: 0, wr_geom: 0,
               geom_value: 0, wr_bounds: 0, new_entry: 0, count: 0, high_water: 0};
         case (act)
            ACT_ALLOC: begin
               if (free_top > 0) begin
                  free_top--;
                  s = free_stack[free_top];
               end else if (next_slot < usable()) begin
                  s = next_slot;
                  next_slot++;
               end else begin
                  r.status = ST_NO_SLOT;
               end
               if (r.status == ST_OK) begin
                  r.slot_out = s;
                  if (s + 1 > high_mark) high_mark = s + 1;
               end
            end
            ACT_FREE: begin
               if (slot >= usable()) r.status = ST_INVALID;
               else if (free_top >= 1024) r.status = ST_FULL;
               else begin
                  free_stack[free_top] = slot;
                  free_top++;
                  geom_shadow[slot] = PRESERVE_ID;
               end
            end
            ACT_UPDATE: begin
               if (slot >= usable()) r.status = ST_INVALID;
               else begin
                  c = w_class(w);
                  if (gid == PRESERVE_ID) begin
                     if (geom_shadow[slot] != PRESERVE_ID) gid = geom_shadow[slot];
                  end else begin
                     geom_shadow[slot] = gid;
                  end
                  r.geom_value = gid;
                  if (pend_valid[slot]) begin
                     old = pend_class[slot];
                     r.pend_index = pend_index[slot];
                     // zero over positive, or negative over zero, leaves the entry alone
                     if (!((c == CLS_ZERO && old == CLS_POS) ||
                           (old == CLS_ZERO && c == CLS_NEG))) begin
                        r.wr_payload = 1;
                        r.wr_geom = (gid != PRESERVE_ID);
                        if (c == CLS_ZERO || c == CLS_POS) begin
                           r.wr_bounds = 1;
                           pend_class[slot] = c;
                        end
                     end
                  end else begin
                     r.pend_index = pend_total;
                     pend_index[slot] = pend_total;
                     pend_class[slot] = c;
                     pend_valid[slot] = 1;
                     pend_total++;
                     r.wr_payload = 1; r.wr_geom = 1; r.wr_bounds = 1; r.new_entry = 1;
                  end
               end
            end
            default: begin
               foreach (pend_valid[i]) pend_valid[i] = 0;
            end
         endcase
         r.count = pend_total;
         if (act == ACT_FLUSH) pend_total = 0;
         r.high_water = high_mark;
         expected_results.insert(expected_results.size(), r);
      endfunction

      function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %0h, got %0h at %0t", field, exp_v, act_v, $time);
      endfunction

      function void check_result(slot_result_type a);
         slot_result_type e;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result item at %0t", $time);
            return;
         end
         e = expected_results.pop_front();
         if (a.status     !== e.status)     report("status", e.status, a.status);
         if (a.slot_out   !== e.slot_out)   report("slot_out", e.slot_out, a.slot_out);
         if (a.pend_index !== e.pend_index) report("pending_index", e.pend_index, a.pend_index);
         if (a.wr_payload !== e.wr_payload) report("write_payload", e.wr_payload, a.wr_payload);
         if (a.wr_geom    !== e.wr_geom)    report("write_geometry", e.wr_geom, a.wr_geom);
         if (a.geom_value !== e.geom_value) report("geometry_value", e.geom_value, a.geom_value);
         if (a.wr_bounds  !== e.wr_bounds)  report("write_bounds", e.wr_bounds, a.wr_bounds);
         if (a.new_entry  !== e.new_entry)  report("new_entry", e.new_entry, a.new_entry);
         if (a.count      !== e.count)      report("pending_count", e.count, a.count);
         if (a.high_water !== e.high_water) report("high_water", e.high_water, a.high_water);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   bit          calm;   // no idling on either side while set

   sauc_req_if req_chan ();
   sauc_rsp_if rsp_chan ();

   slot_table_scoreboard slot_tables = new();

   slot_allocator_update_coalescer uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   initial begin
      #20ms;
      $display("slot_allocator_update_coalescer_test: errors");
      $finish;
   end

   // item acceptance on both channels
   always @(posedge clock) begin
      slot_result_type got;
      if (!reset && req_chan.valid && req_chan.ready)
         slot_tables.note_request(action_type'(req_chan.action), req_chan.slot,
                                  req_chan.geometry_id, req_chan.bounds_w_bits);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status     = status_type'(rsp_chan.status);
         got.slot_out   = rsp_chan.slot_out;
         got.pend_index = rsp_chan.pending_index;
         got.wr_payload = rsp_chan.write_payload;
         got.wr_geom    = rsp_chan.write_geometry;
         got.geom_value = rsp_chan.geometry_value;
         got.wr_bounds  = rsp_chan.write_bounds;
         got.new_entry  = rsp_chan.new_entry;
         got.count      = rsp_chan.pending_count;
         got.high_water = rsp_chan.high_water;
         slot_tables.check_result(got);
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= 14);
   end

   task automatic send_item(action_type act, logic [15:0] slot, logic [31:0] gid,
                            logic [31:0] w);
      if (!calm && $urandom_range(99) < 14) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.action        <= act;
      req_chan.slot          <= slot;
      req_chan.geometry_id   <= gid;
      req_chan.bounds_w_bits <= w;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (slot_tables.expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_max_instances(logic [10:0] value);
      wait_drained();
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {REG_MAX_INST, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      slot_tables.limit_reg = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_w();
      logic [31:0] m;
      m = $urandom();
      case ($urandom_range(5))
         0: return {1'b0, m[30:0]} | 32'h0080_0000 & ~32'h7F80_0000 | 32'h3F80_0000;
         1: return {1'b1, m[30:0]};
         2: return {m[31], 31'd0};
         3: return {m[31], 8'hFF, m[22:0] | 23'd1};
         4: return 32'h7F80_0000;
         default: return m;
      endcase
   endfunction

   function automatic logic [31:0] pick_gid();
      case ($urandom_range(3))
         0: return PRESERVE_ID;
         1: return $urandom_range(15);
         default: return $urandom();
      endcase
   endfunction

   task automatic random_items(int count, int slot_span);
      int r;
      logic [15:0] s;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         s = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(slot_span));
         if (r < 25) send_item(ACT_ALLOC, 16'($urandom()), $urandom(), $urandom());
         else if (r < 43) send_item(ACT_FREE, s, $urandom(), $urandom());
         else if (r < 92) send_item(ACT_UPDATE, s, pick_gid(), pick_w());
         else send_item(ACT_FLUSH, s, $urandom(), $urandom());
      end
   endtask

   initial begin
      calm = 1'b0;
      reset = 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.action <= ACT_ALLOC;
      req_chan.slot <= '0;
      req_chan.geometry_id <= '0;
      req_chan.bounds_w_bits <= '0;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: allocation, merge rules, invalid slots, flush
      send_item(ACT_ALLOC, 0, 0, 0);
      send_item(ACT_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_UPDATE, 0, 32'd7, 32'h3F80_0000);      // new entry, positive
      send_item(ACT_UPDATE, 0, PRESERVE_ID, 32'h0000_0000); // zero over positive
      send_item(ACT_UPDATE, 0, PRESERVE_ID, 32'hBF80_0000); // negative merge, shadow id
      send_item(ACT_UPDATE, 1, PRESERVE_ID, 32'h8000_0000); // new entry, no shadow
      send_item(ACT_UPDATE, 1, PRESERVE_ID, 32'hBF80_0000); // negative over zero
      send_item(ACT_UPDATE, 1, PRESERVE_ID, 32'h7FC0_0001); // NaN merge, keep id
      send_item(ACT_UPDATE, 1, 32'hFFFF_FFFE, 32'h7F80_0000);
      send_item(ACT_UPDATE, 1, 32'h0, 32'h0000_0000);
      send_item(ACT_UPDATE, 1023, 32'h1234_5678, 32'hFFFF_FFFF);
      send_item(ACT_UPDATE, 1024, 32'h1, 32'h3F80_0000);
      send_item(ACT_UPDATE, 16'hFFFF, 32'h1, 32'h3F80_0000);
      send_item(ACT_FREE, 16'hFFFF, 0, 0);
      send_item(ACT_FREE, 0, 0, 0);
      send_item(ACT_UPDATE, 0, PRESERVE_ID, 32'h3F80_0000);
      send_item(ACT_FLUSH, 0, 0, 0);
      send_item(ACT_FLUSH, 0, 0, 0);
      send_item(ACT_ALLOC, 0, 0, 0);
      send_item(ACT_ALLOC, 0, 0, 0);

      // small limit: out of slots soon
      write_max_instances(11'd2);
      repeat (4) send_item(ACT_ALLOC, 0, 0, 0);
      random_items(150, 3);

      write_max_instances(11'd0);
      send_item(ACT_ALLOC, 0, 0, 0);
      send_item(ACT_FREE, 0, 0, 0);
      send_item(ACT_UPDATE, 0, 32'h5, 32'h3F80_0000);
      send_item(ACT_FLUSH, 0, 0, 0);

      // above the built size; fill the free stack past full
      write_max_instances(11'd2047);
      calm = 1'b1;
      for (int i = 0; i < 1026; i++) send_item(ACT_FREE, 16'($urandom_range(1023)), 0, 0);
      calm = 1'b0;
      for (int i = 0; i < 40; i++) send_item(ACT_ALLOC, 0, 0, 0);
      random_items(100, 1023);

      write_max_instances(11'd40);
      random_items(250, 45);
      wait_drained();
      random_items(100, 45);

      write_max_instances(11'd1024);
      random_items(100, 60);
      calm = 1'b1;
      random_items(60, 60);
      calm = 1'b0;
      random_items(40, 1100);

      wait_drained();
      repeat (20) @(posedge clock);
      if (slot_tables.errors == 0 && slot_tables.expected_results.size() == 0) begin
         $display("slot_allocator_update_coalescer_test: clean");
      end else begin
         $display("slot_allocator_update_coalescer_test: errors");
      end
      $finish;
   end
endmodule
